// ===== hdl/lp2c_pkg.sv =====
// Shared constants for the lidar polar-to-cartesian converter.
package lp2c_pkg;

   // Q30 fixed point used inside the sine evaluator
   localparam int TRIG_Q = 30;
   localparam int TRIG_W = TRIG_Q + 1;

   typedef logic [TRIG_W-1:0] q30_type;

   localparam q30_type ONE_Q30 = q30_type'(1) << TRIG_Q;

   // (pi/2)^k / k! in Q30, highest order first: k = 13, 11, 9, 7, 5, 3, 1
   localparam int HORNER_TERMS = 7;
   localparam q30_type HORNER_COEF [HORNER_TERMS] = '{
      31'd61, 31'd3864, 31'd172272, 31'd5026995,
      31'd85569306, 31'd693598668, 31'd1686629713
   };

   // Pipeline depths
   localparam int SINE_LATENCY  = 9;
   localparam int SCALE_LATENCY = 3;
   localparam int TOTAL_LATENCY = 1 + SINE_LATENCY + SCALE_LATENCY;

endpackage

// ===== hdl/lp2c_if.sv =====
// Channel interfaces: sample beats, point beats and the elevation write port.

interface lp2c_req_if #(
   parameter int ANGLE_BITS = 16,
   parameter int RANGE_BITS = 18
);
   logic                  valid;
   logic                  ready;
   logic [ANGLE_BITS-1:0] azimuth_raw;
   logic [RANGE_BITS-1:0] range_quarter;

   modport source (output valid, azimuth_raw, range_quarter, input ready);
   modport sink   (input valid, azimuth_raw, range_quarter, output ready);
endinterface

interface lp2c_rsp_if #(
   parameter int RANGE_BITS = 18
);
   logic                       valid;
   logic                       ready;
   logic signed [RANGE_BITS:0] x_pos;
   logic signed [RANGE_BITS:0] y_pos;
   logic signed [RANGE_BITS:0] z_pos;

   modport source (output valid, x_pos, y_pos, z_pos, input ready);
   modport sink   (input valid, x_pos, y_pos, z_pos, output ready);
endinterface

interface lp2c_csr_if #(
   parameter int ANGLE_BITS = 16
);
   logic                  valid;
   logic                  ready;
   logic [ANGLE_BITS-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

// ===== hdl/lp2c_sine.sv =====
// Pipelined fixed-point sine lane: quadrant fold, Horner polynomial, rounding.
module lp2c_sine import lp2c_pkg::*; #(
   parameter int ANGLE_BITS     = 16,
   parameter int TRIG_FRAC_BITS = 15
) (
   input  logic                    clock,
   input  logic                    advance,
   input  logic [ANGLE_BITS-1:0]   angle,
   output logic [TRIG_FRAC_BITS:0] mag,
   output logic                    neg
);

   localparam int PHASE_BITS  = ANGLE_BITS - 1;
   localparam int T_SHIFT     = TRIG_Q - (ANGLE_BITS - 2);
   localparam int MAG_W       = TRIG_FRAC_BITS + 1;
   localparam int ROUND_SHIFT = TRIG_Q - TRIG_FRAC_BITS;
   localparam int RSUM_W      = TRIG_W + 1;
   localparam int LAST_HORNER = HORNER_TERMS;

   localparam logic [PHASE_BITS-1:0] QUARTER = {1'b1, {(ANGLE_BITS-2){1'b0}}};
   localparam logic [RSUM_W-1:0] ROUND_HALF = RSUM_W'(1) << (ROUND_SHIFT - 1);

   // stage 1: fold into first quadrant, t = p/Q in Q30, u = t*t
   logic [1:0]            quad;
   logic [PHASE_BITS-1:0] phase_low;
   logic [PHASE_BITS-1:0] phase;
   q30_type               t_in;
   logic [2*TRIG_W-1:0]   sq;

   assign quad      = angle[ANGLE_BITS-1 -: 2];
   assign phase_low = {1'b0, angle[ANGLE_BITS-3:0]};
   assign phase     = quad[0] ? (QUARTER - phase_low) : phase_low;
   assign t_in      = TRIG_W'(phase) << T_SHIFT;
   assign sq        = t_in * t_in;

   q30_type t_ff   [1:LAST_HORNER];
   q30_type u_ff   [1:LAST_HORNER-1];
   q30_type s_ff   [2:LAST_HORNER];
   logic    neg_ff [1:SINE_LATENCY];

   // stages 2..7: one Horner step each, s = K - u*s
   q30_type             s_prev [2:LAST_HORNER];
   logic [2*TRIG_W-1:0] prod   [2:LAST_HORNER];
   q30_type             s_in   [2:LAST_HORNER];

   always_comb begin
      for (int j = 2; j <= LAST_HORNER; j++) begin
         s_prev[j] = (j == 2) ? HORNER_COEF[0] : s_ff[(j == 2) ? 2 : j-1];
         prod[j]   = u_ff[j-1] * s_prev[j];
         s_in[j]   = HORNER_COEF[j-1] - prod[j][TRIG_Q +: TRIG_W];
      end
   end

   // stage 8: v = t*s
   logic [2*TRIG_W-1:0] vprod;
   q30_type             v_ff;

   assign vprod = t_ff[LAST_HORNER] * s_ff[LAST_HORNER];

   // stage 9: clamp to one, round half up to the output fraction
   q30_type             v_clamp;
   logic [RSUM_W-1:0]   rsum;
   logic [MAG_W-1:0]    mag_ff;

   assign v_clamp = (v_ff > ONE_Q30) ? ONE_Q30 : v_ff;
   assign rsum    = {1'b0, v_clamp} + ROUND_HALF;

   always_ff @(posedge clock) begin
      if (advance) begin
         t_ff[1]   <= t_in;
         u_ff[1]   <= sq[TRIG_Q +: TRIG_W];
         neg_ff[1] <= quad[1];
         for (int j = 2; j <= LAST_HORNER; j++) begin
            t_ff[j] <= t_ff[j-1];
            s_ff[j] <= s_in[j];
         end
         for (int j = 2; j < LAST_HORNER; j++) begin
            u_ff[j] <= u_ff[j-1];
         end
         for (int j = 2; j <= SINE_LATENCY; j++) begin
            neg_ff[j] <= neg_ff[j-1];
         end
         v_ff   <= vprod[TRIG_Q +: TRIG_W];
         mag_ff <= rsum[ROUND_SHIFT +: MAG_W];
      end
   end

   assign mag = mag_ff;
   assign neg = neg_ff[SINE_LATENCY];

endmodule

// ===== hdl/lp2c_scale.sv =====
// Range scaling pipeline: d*cos(el)*cos/sin(az) and d*sin(el), rounding and sign.
module lp2c_scale #(
   parameter int RANGE_BITS     = 18,
   parameter int TRIG_FRAC_BITS = 15
) (
   input  logic                       clock,
   input  logic                       advance,
   input  logic [RANGE_BITS-1:0]      range_quarter,
   input  logic [TRIG_FRAC_BITS:0]    cos_el,
   input  logic [TRIG_FRAC_BITS:0]    sin_el,
   input  logic [TRIG_FRAC_BITS:0]    cos_az,
   input  logic [TRIG_FRAC_BITS:0]    sin_az,
   input  logic                       cos_el_neg,
   input  logic                       sin_el_neg,
   input  logic                       cos_az_neg,
   input  logic                       sin_az_neg,
   output logic signed [RANGE_BITS:0] x_pos,
   output logic signed [RANGE_BITS:0] y_pos,
   output logic signed [RANGE_BITS:0] z_pos,
   output logic                       nonzero
);

   localparam int MAG_W  = TRIG_FRAC_BITS + 1;
   localparam int PW     = RANGE_BITS + MAG_W;
   localparam int LO     = PW / 2;
   localparam int HI     = PW - LO;
   localparam int SUMW   = PW + MAG_W + 1;
   localparam int ZSUMW  = PW + 1;
   localparam logic [SUMW-1:0]  HALF2 = SUMW'(1) << (2*TRIG_FRAC_BITS - 1);
   localparam logic [ZSUMW-1:0] HALF1 = ZSUMW'(1) << (TRIG_FRAC_BITS - 1);

   // stage 1: d*cos(el) shared by x and y, d*sin(el) for z
   logic [PW-1:0]    pce_ff;
   logic [PW-1:0]    pz_ff;
   logic [MAG_W-1:0] ca_ff;
   logic [MAG_W-1:0] sa_ff;
   logic [2:0]       sign1_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         pce_ff   <= range_quarter * cos_el;
         pz_ff    <= range_quarter * sin_el;
         ca_ff    <= cos_az;
         sa_ff    <= sin_az;
         sign1_ff <= {sin_el_neg, cos_el_neg ^ sin_az_neg, cos_el_neg ^ cos_az_neg};
      end
   end

   // stage 2: split the wide product into halves times the azimuth factor; round z
   logic [LO-1:0]         pce_lo;
   logic [HI-1:0]         pce_hi;
   logic [ZSUMW-1:0]      zsum;
   logic [LO+MAG_W-1:0]   xlo_ff;
   logic [HI+MAG_W-1:0]   xhi_ff;
   logic [LO+MAG_W-1:0]   ylo_ff;
   logic [HI+MAG_W-1:0]   yhi_ff;
   logic [RANGE_BITS-1:0] zm_ff;
   logic [2:0]            sign2_ff;

   assign pce_lo = pce_ff[LO-1:0];
   assign pce_hi = pce_ff[PW-1:LO];
   assign zsum   = {1'b0, pz_ff} + HALF1;

   always_ff @(posedge clock) begin
      if (advance) begin
         xlo_ff   <= pce_lo * ca_ff;
         xhi_ff   <= pce_hi * ca_ff;
         ylo_ff   <= pce_lo * sa_ff;
         yhi_ff   <= pce_hi * sa_ff;
         zm_ff    <= zsum[TRIG_FRAC_BITS +: RANGE_BITS];
         sign2_ff <= sign1_ff;
      end
   end

   // stage 3: recombine, round half away from zero, apply sign, flag empty points
   logic [SUMW-1:0]        xsum;
   logic [SUMW-1:0]        ysum;
   logic [RANGE_BITS-1:0]  xm;
   logic [RANGE_BITS-1:0]  ym;
   logic [RANGE_BITS:0]    xe;
   logic [RANGE_BITS:0]    ye;
   logic [RANGE_BITS:0]    ze;
   logic [RANGE_BITS:0]    x_ff;
   logic [RANGE_BITS:0]    y_ff;
   logic [RANGE_BITS:0]    z_ff;
   logic                   nonzero_ff;

   assign xsum = (SUMW'(xhi_ff) << LO) + SUMW'(xlo_ff) + HALF2;
   assign ysum = (SUMW'(yhi_ff) << LO) + SUMW'(ylo_ff) + HALF2;
   assign xm   = xsum[2*TRIG_FRAC_BITS +: RANGE_BITS];
   assign ym   = ysum[2*TRIG_FRAC_BITS +: RANGE_BITS];
   assign xe   = {1'b0, xm};
   assign ye   = {1'b0, ym};
   assign ze   = {1'b0, zm_ff};

   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff       <= sign2_ff[0] ? (~xe + 1'b1) : xe;
         y_ff       <= sign2_ff[1] ? (~ye + 1'b1) : ye;
         z_ff       <= sign2_ff[2] ? (~ze + 1'b1) : ze;
         nonzero_ff <= (|xm) | (|ym) | (|zm_ff);
      end
   end

   assign x_pos   = signed'(x_ff);
   assign y_pos   = signed'(y_ff);
   assign z_pos   = signed'(z_ff);
   assign nonzero = nonzero_ff;

endmodule

// ===== hdl/lidar_polar_to_cartesian.sv =====
// Lidar polar-to-cartesian converter: top level with handshake and valid pipeline.
//
// Usage:
//   req_chan carries one lidar sample per beat (azimuth_raw, range_quarter).
//   rsp_chan carries one point per beat (x_pos, y_pos, z_pos), signed quarter
//   units. A sample whose three coordinates all round to zero gives no beat.
//   csr_chan writes the elevation angle; it is ready whenever reset is low and
//   should only be written while no samples are in flight.
//   An accepted sample passes one input register, nine stages of the sine lanes
//   (fold, six Horner steps, product, rounding) and three stages of range
//   scaling on its way to its point on rsp_chan.
//   Throughput is one sample per cycle while rsp_chan does not stall; the four sine
//   lanes and the scaling multipliers are fully pipelined.
//   Reset clears all valid bits and sets the elevation to zero; req_chan and
//   csr_chan hold ready low while reset is high.
//   When rsp_chan stalls with a point waiting, the whole pipeline holds and
//   req_chan.ready drops; dropped points never stall the pipe.
module lidar_polar_to_cartesian import lp2c_pkg::*; #(
   parameter int ANGLE_BITS     = 16,
   parameter int RANGE_BITS     = 18,
   parameter int TRIG_FRAC_BITS = 15
) (
   input  logic      clock,
   input  logic      reset,
   lp2c_req_if.sink  req_chan,
   lp2c_rsp_if.source rsp_chan,
   lp2c_csr_if.sink  csr_chan
);

   localparam logic [ANGLE_BITS-1:0] QUARTER_TURN = {2'b01, {(ANGLE_BITS-2){1'b0}}};

   // elevation register
   logic [ANGLE_BITS-1:0] elevation_ff;

   assign csr_chan.ready = ~reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         elevation_ff <= '0;
      end else if (csr_chan.valid) begin
         elevation_ff <= csr_chan.data;
      end
   end

   // global pipeline enable
   logic                     advance;
   logic                     out_valid;
   logic                     nonzero;
   logic [TOTAL_LATENCY-1:0] valid_ff;

   assign out_valid      = valid_ff[TOTAL_LATENCY-1] & nonzero;
   assign advance        = ~out_valid | rsp_chan.ready;
   assign req_chan.ready = advance & ~reset;
   assign rsp_chan.valid = out_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[TOTAL_LATENCY-2:0], req_chan.valid};
      end
   end

   // input register and range delay line matching the sine lanes
   logic [ANGLE_BITS-1:0] azimuth_ff;
   logic [ANGLE_BITS-1:0] elev_ff;
   logic [RANGE_BITS-1:0] range_ff [0:SINE_LATENCY];

   always_ff @(posedge clock) begin
      if (advance) begin
         azimuth_ff  <= req_chan.azimuth_raw;
         elev_ff     <= elevation_ff;
         range_ff[0] <= req_chan.range_quarter;
         for (int i = 1; i <= SINE_LATENCY; i++) begin
            range_ff[i] <= range_ff[i-1];
         end
      end
   end

   // four sine lanes; cosine is sine a quarter turn ahead
   logic [ANGLE_BITS-1:0]   azimuth_cos_angle;
   logic [ANGLE_BITS-1:0]   elev_cos_angle;
   logic [TRIG_FRAC_BITS:0] sin_az;
   logic [TRIG_FRAC_BITS:0] cos_az;
   logic [TRIG_FRAC_BITS:0] sin_el;
   logic [TRIG_FRAC_BITS:0] cos_el;
   logic                    sin_az_neg;
   logic                    cos_az_neg;
   logic                    sin_el_neg;
   logic                    cos_el_neg;

   assign azimuth_cos_angle = azimuth_ff + QUARTER_TURN;
   assign elev_cos_angle    = elev_ff + QUARTER_TURN;

   lp2c_sine #(.ANGLE_BITS(ANGLE_BITS), .TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_sin_az (
      .clock(clock), .advance(advance), .angle(azimuth_ff),
      .mag(sin_az), .neg(sin_az_neg)
   );

   lp2c_sine #(.ANGLE_BITS(ANGLE_BITS), .TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_cos_az (
      .clock(clock), .advance(advance), .angle(azimuth_cos_angle),
      .mag(cos_az), .neg(cos_az_neg)
   );

   lp2c_sine #(.ANGLE_BITS(ANGLE_BITS), .TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_sin_el (
      .clock(clock), .advance(advance), .angle(elev_ff),
      .mag(sin_el), .neg(sin_el_neg)
   );

   lp2c_sine #(.ANGLE_BITS(ANGLE_BITS), .TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_cos_el (
      .clock(clock), .advance(advance), .angle(elev_cos_angle),
      .mag(cos_el), .neg(cos_el_neg)
   );

   // range scaling; its last stage is the output register
   lp2c_scale #(.RANGE_BITS(RANGE_BITS), .TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_scale (
      .clock         (clock),
      .advance       (advance),
      .range_quarter (range_ff[SINE_LATENCY]),
      .cos_el        (cos_el),
      .sin_el        (sin_el),
      .cos_az        (cos_az),
      .sin_az        (sin_az),
      .cos_el_neg    (cos_el_neg),
      .sin_el_neg    (sin_el_neg),
      .cos_az_neg    (cos_az_neg),
      .sin_az_neg    (sin_az_neg),
      .x_pos         (rsp_chan.x_pos),
      .y_pos         (rsp_chan.y_pos),
      .z_pos         (rsp_chan.z_pos),
      .nonzero       (nonzero)
   );

   // a delivered point is never all zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.x_pos != 0 || rsp_chan.y_pos != 0 || rsp_chan.z_pos != 0))
      else $error("empty point delivered");

   // a stalled output holds the input side off
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.ready) |-> !req_chan.ready)
      else $error("input accepted while output stalled");

   // reset empties the pipeline
   assert property (@(posedge clock) reset |=> !rsp_chan.valid)
      else $error("point delivered right after reset");

   // a held point keeps its pipeline slot while stalled
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.ready) |=> $stable(valid_ff))
      else $error("valid pipeline moved during stall");

endmodule

// ===== verif/lidar_polar_to_cartesian_chk.sv =====
// Point checker: watches the sample, point and elevation channels and scores points.
module lidar_polar_to_cartesian_chk import lp2c_pkg::*; (
   input  logic  clock,
   input  logic  reset,
   lp2c_req_if   req_chan,
   lp2c_rsp_if   rsp_chan,
   lp2c_csr_if   csr_chan,
   output int    fail_count,
   output int    pending_points
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ANGLE_BITS     = 16;
   localparam int RANGE_BITS     = 18;
   localparam int TRIG_FRAC_BITS = 15;
   localparam logic [ANGLE_BITS-1:0] QUARTER_TURN = 16'h4000;
   localparam logic [63:0] QUARTER_SPAN = 64'd16384;

   typedef struct packed {
      logic signed [RANGE_BITS:0] x;
      logic signed [RANGE_BITS:0] y;
      logic signed [RANGE_BITS:0] z;
   } point_type;

   point_type             expected_points [$];
   logic [ANGLE_BITS-1:0] elev_setting = '0;
   int                    fails = 0;
   int                    queued = 0;

   assign fail_count     = fails;
   assign pending_points = queued;

   // sin(pi/2 * phase/QUARTER) over one quarter wave, magnitude with 15 fraction bits
   function automatic logic [63:0] quarter_wave(input logic [63:0] phase);
      logic [63:0] t, u, s, v, r;
      t = phase << (TRIG_Q - (ANGLE_BITS - 2));
      u = (t * t) >> TRIG_Q;
      s = 64'(HORNER_COEF[0]);
      for (int k = 1; k < HORNER_TERMS; k++)
         s = 64'(HORNER_COEF[k]) - ((u * s) >> TRIG_Q);
      v = (t * s) >> TRIG_Q;
      if (v > 64'(ONE_Q30))
         v = 64'(ONE_Q30);
      r = (v + (64'd1 << (TRIG_Q - 1 - TRIG_FRAC_BITS))) >> (TRIG_Q - TRIG_FRAC_BITS);
      if (r > (64'd1 << TRIG_FRAC_BITS))
         r = 64'd1 << TRIG_FRAC_BITS;
      return r;
   endfunction

   // full-turn sine: fold into the first quadrant, sign from the top bit
   function automatic logic [63:0] sine_mag(input logic [ANGLE_BITS-1:0] ang,
                                            output logic neg);
      logic [1:0]  quad;
      logic [63:0] phase;
      quad  = ang[ANGLE_BITS-1 -: 2];
      phase = 64'(ang[ANGLE_BITS-3:0]);
      neg   = quad[1];
      if (quad[0])
         phase = QUARTER_SPAN - phase;
      return quarter_wave(phase);
   endfunction

   function automatic logic signed [RANGE_BITS:0] signed_coord(input logic [63:0] mag,
                                                               input logic neg);
      if (neg && mag != 0)
         return (RANGE_BITS+1)'(64'd0 - mag);
      return (RANGE_BITS+1)'(mag);
   endfunction

   // returns 1 when the sample yields a point, 0 when it is dropped
   function automatic logic convert_sample(input logic [ANGLE_BITS-1:0] el,
                                           input logic [ANGLE_BITS-1:0] az,
                                           input logic [RANGE_BITS-1:0] range_val,
                                           output point_type pt);
      logic [63:0] ce, se, ca, sa, d, xm, ym, zm;
      logic        n_ce, n_se, n_ca, n_sa;
      ce = sine_mag(el + QUARTER_TURN, n_ce);
      se = sine_mag(el, n_se);
      ca = sine_mag(az + QUARTER_TURN, n_ca);
      sa = sine_mag(az, n_sa);
      d  = 64'(range_val);
      xm = (d * (ce * ca) + (64'd1 << (2*TRIG_FRAC_BITS - 1))) >> (2*TRIG_FRAC_BITS);
      ym = (d * (ce * sa) + (64'd1 << (2*TRIG_FRAC_BITS - 1))) >> (2*TRIG_FRAC_BITS);
      zm = (d * se + (64'd1 << (TRIG_FRAC_BITS - 1))) >> TRIG_FRAC_BITS;
      pt.x = signed_coord(xm, n_ce ^ n_ca);
      pt.y = signed_coord(ym, n_ce ^ n_sa);
      pt.z = signed_coord(zm, n_se);
      return (xm | ym | zm) != 0;
   endfunction

   always @(posedge clock) begin
      point_type want;
      point_type got;
      if (reset) begin
         expected_points.delete();
         elev_setting = '0;
      end else begin
         // score a point beat against the oldest prediction
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.x = rsp_chan.x_pos;
            got.y = rsp_chan.y_pos;
            got.z = rsp_chan.z_pos;
            if (expected_points.size() == 0) begin
               $error("unexpected point x=%0d y=%0d z=%0d", got.x, got.y, got.z);
               fails++;
            end else begin
               want = expected_points.pop_front();
               if (got.x !== want.x) begin
                  $error("x_pos: expected %0d, got %0d", want.x, got.x);
                  fails++;
               end
               if (got.y !== want.y) begin
                  $error("y_pos: expected %0d, got %0d", want.y, got.y);
                  fails++;
               end
               if (got.z !== want.z) begin
                  $error("z_pos: expected %0d, got %0d", want.z, got.z);
                  fails++;
               end
            end
         end
         // predict from each accepted sample beat
         if (req_chan.valid && req_chan.ready) begin
            if (convert_sample(elev_setting, req_chan.azimuth_raw,
                               req_chan.range_quarter, want))
               expected_points.insert(expected_points.size(), want);
         end
         // elevation write
         if (csr_chan.valid && csr_chan.ready)
            elev_setting = csr_chan.data;
      end
      queued <= expected_points.size();
   end

endmodule

// ===== verif/lidar_polar_to_cartesian_tb.sv =====
// Testbench top: clock, reset, sample and elevation stimulus, sink stalls, verdict.
module lidar_polar_to_cartesian_tb import lp2c_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 200000;
   localparam int SEGMENT_LEN = 236;

   logic clock = 1'b0;
   logic reset;
   int   fail_count;
   int   pending_points;
   int   cycle_count = 0;
   int   sink_hold = 0;
   bit   idle_on = 1'b0;

   lp2c_req_if req_chan ();
   lp2c_rsp_if rsp_chan ();
   lp2c_csr_if csr_chan ();

   lidar_polar_to_cartesian u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   lidar_polar_to_cartesian_chk u_chk (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .rsp_chan       (rsp_chan),
      .csr_chan       (csr_chan),
      .fail_count     (fail_count),
      .pending_points (pending_points)
   );

   always #2 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("lidar_polar_to_cartesian_tb: errors");
         $finish;
      end
   end

   // point sink: random stall bursts, only while idle_on is set
   always @(posedge clock) begin
      if (sink_hold > 0)
         sink_hold--;
      else if (idle_on && $urandom_range(0, 6) == 0)
         sink_hold = $urandom_range(1, 4);
      rsp_chan.ready <= (sink_hold == 0);
   end

   // one sample beat, with an optional source gap first
   task automatic send_sample(input logic [15:0] az, input logic [17:0] range_val);
      int gap;
      gap = 0;
      if (idle_on && $urandom_range(0, 5) == 0)
         gap = $urandom_range(1, 4);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid         <= 1'b1;
      req_chan.azimuth_raw   <= az;
      req_chan.range_quarter <= range_val;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   // wait for all points, then let dropped samples clear the pipe
   task automatic drain_points();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_points != 0) @(posedge clock);
      repeat (TOTAL_LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_elevation(input logic [15:0] el);
      drain_points();
      csr_chan.valid <= 1'b1;
      csr_chan.data  <= el;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      csr_chan.valid <= 1'b0;
   endtask

   function automatic logic [17:0] pick_range();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return 18'($urandom_range(1, 4));
         2:       return 18'h3FFFF;
         3:       return 18'($urandom_range(0, 255));
         default: return 18'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] pick_azimuth();
      // quadrant edges get extra weight
      if ($urandom_range(0, 4) == 0)
         return 16'($urandom_range(0, 3) * 16384 + $urandom_range(0, 2) - 1);
      return 16'($urandom);
   endfunction

   initial begin
      logic [15:0] seg_elev [8];
      reset                  <= 1'b1;
      req_chan.valid         <= 1'b0;
      req_chan.azimuth_raw   <= '0;
      req_chan.range_quarter <= '0;
      csr_chan.valid         <= 1'b0;
      csr_chan.data          <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: elevation at its reset value
      send_sample(16'd0, 18'd0);
      send_sample(16'd0, 18'd1);
      send_sample(16'd16384, 18'd1);
      send_sample(16'd32768, 18'd2);
      send_sample(16'd49152, 18'h3FFFF);
      send_sample(16'hFFFF, 18'h3FFFF);
      send_sample(16'd8192, 18'd1);
      send_sample(16'd8192, 18'h3FFFF);
      send_sample(16'd0, 18'h3FFFF);
      // straight up: x and y vanish
      write_elevation(16'd16384);
      send_sample(16'd0, 18'd5);
      send_sample(16'd12345, 18'h3FFFF);
      send_sample(16'd0, 18'd0);
      write_elevation(16'hFFFF);
      send_sample(16'd16383, 18'h3FFFF);
      send_sample(16'd49152, 18'd3);
      write_elevation(16'd32768);
      send_sample(16'd8192, 18'd1000);
      write_elevation(16'd49152);
      send_sample(16'd40000, 18'h3FFFF);

      // random segments, one elevation each; the last runs without stalls
      seg_elev = '{16'd0, 16'hFFFF, 16'd16384, 16'($urandom), 16'd32768,
                   16'd49152, 16'($urandom), 16'd8192};
      idle_on = 1'b1;
      foreach (seg_elev[s]) begin
         write_elevation(seg_elev[s]);
         if (s == 7)
            idle_on = 1'b0;
         repeat (SEGMENT_LEN) send_sample(pick_azimuth(), pick_range());
      end

      drain_points();
      if (fail_count == 0)
         $display("lidar_polar_to_cartesian_tb: clean");
      else
         $display("lidar_polar_to_cartesian_tb: errors");
      $finish;
   end

endmodule
